[rtl/mma_pkg.sv]
package mma_pkg;

	localparam int unsigned MAX_DIM_DEF = 8;

	localparam int unsigned DIM_W  = 4;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned OP_W   = 3;
	localparam int unsigned FACT_W = 32;
	localparam int unsigned ACC_W  = 64;
	localparam int unsigned CFG_W  = 2;

	localparam logic [OP_W-1:0] OP_WRITE_X = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE_Y = 3'd1;
	localparam logic [OP_W-1:0] OP_WRITE_Z = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR_Z = 3'd3;
	localparam logic [OP_W-1:0] OP_RUN     = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_Z  = 3'd5;

	localparam logic [CFG_W-1:0] CFG_ROWS_X    = 2'd0;
	localparam logic [CFG_W-1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [CFG_W-1:0] CFG_COLS_Y    = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	// source of the word written into the z store
	typedef enum logic [1:0] {
		ZSRC_IN,
		ZSRC_ZERO,
		ZSRC_MAC
	} zsrc_t;

	// store and mac controls from the sequencer
	typedef struct packed {
		logic  x_we;
		logic  y_we;
		logic  z_we;
		zsrc_t z_src;
		logic  rd_en;
		logic  mul_en;
	} mma_ctl_t;

endpackage

[rtl/matrix_multiply_accumulate.sv]
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------------------------
// item      | in        | start && !busy            | operation, row, col, factor_value,
//           |           |                           | accum_value
// result    | out       | result_valid, one cycle   | result_kind, z_value, overflow
// config    | in        | cfg_write                 | cfg_index, cfg_data
//
// writes of x, y or z cause no busy time, and an item is taken every cycle while idle
// a read returns its word in the cycle after it is taken, with no busy time
// clear sweeps the z store one entry a cycle, holding busy until every entry is zeroed
// run: busy through read, multiply and accumulate for each of the n*p*m terms through the one mac
// and the single z store port, run-done word in the cycle busy drops
// reset clears control state only; store contents are undefined until written
// the receiver cannot stall: each result word is on the ports for exactly one cycle
module matrix_multiply_accumulate
	import mma_pkg::*;
#(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF,
	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM,
	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,

	// item channel
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          operation,
	input  logic [IDX_W-1:0]         row,
	input  logic [IDX_W-1:0]         col,
	input  logic signed [FACT_W-1:0] factor_value,
	input  logic signed [ACC_W-1:0]  accum_value,

	// configuration write port
	input  logic                     cfg_write,
	input  logic [CFG_W-1:0]         cfg_index,
	input  logic [DIM_W-1:0]         cfg_data,

	// result channel
	output logic                     result_valid,
	output logic                     result_kind,
	output logic signed [ACC_W-1:0]  z_value,
	output logic                     overflow
);

	mma_ctl_t                 ctl;
	logic [AW-1:0]            addr_x, addr_y, addr_z;
	logic signed [FACT_W-1:0] x_rd, y_rd;
	logic signed [ACC_W-1:0]  z_rd;
	logic signed [ACC_W-1:0]  mac_sum;
	logic                     mac_sat;

	// sequencer: item decode, config registers, loop counters, clear sweep, result word
	mma_seq #(
		.MAX_DIM (MAX_DIM)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.operation    (operation),
		.row          (row),
		.col          (col),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mac_sat      (mac_sat),
		.z_rd         (z_rd),
		.busy         (busy),
		.ctl          (ctl),
		.addr_x       (addr_x),
		.addr_y       (addr_y),
		.addr_z       (addr_z),
		.result_valid (result_valid),
		.result_kind  (result_kind),
		.z_value      (z_value),
		.overflow     (overflow)
	);

	// x, y and z stores, one write and one registered read each per cycle
	mma_stores #(
		.MAX_DIM (MAX_DIM)
	) u_stores (
		.clk          (clk),
		.ctl          (ctl),
		.addr_x       (addr_x),
		.addr_y       (addr_y),
		.addr_z       (addr_z),
		.factor_value (factor_value),
		.accum_value  (accum_value),
		.mac_sum      (mac_sum),
		.x_rd         (x_rd),
		.y_rd         (y_rd),
		.z_rd         (z_rd)
	);

	// shared mac: registered 32x32 product, then saturating 64-bit add into z
	mma_mac u_mac (
		.clk    (clk),
		.mul_en (ctl.mul_en),
		.x_rd   (x_rd),
		.y_rd   (y_rd),
		.z_acc  (z_rd),
		.sum    (mac_sum),
		.sat    (mac_sat)
	);

`ifndef SYNTHESIS
	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_READ_Z) |=>
		(result_valid && result_kind == KIND_READ))
		else $error("read item gave no data word in the next cycle");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_WRITE_X || operation == OP_WRITE_Y ||
		operation == OP_WRITE_Z || operation == OP_CLEAR_Z)) |=> !result_valid)
		else $error("write or clear gave a result word");

	a_run_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_RUN) |=> busy)
		else $error("run did not hold the block busy");

	a_run_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_RUN) |-> (!busy && $past(busy)))
		else $error("run-done word not at the end of a busy run");

	a_read_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == KIND_READ) |-> !overflow)
		else $error("read data word carries overflow");
`endif

endmodule

[rtl/mma_mac.sv]
module mma_mac
	import mma_pkg::*;
(
	input  logic                     clk,
	input  logic                     mul_en,
	input  logic signed [FACT_W-1:0] x_rd,
	input  logic signed [FACT_W-1:0] y_rd,
	input  logic signed [ACC_W-1:0]  z_acc,
	output logic signed [ACC_W-1:0]  sum,
	output logic                     sat
);

	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic signed [ACC_W-1:0] prod_full;
	logic signed [ACC_W-1:0] prod_q;
	logic signed [ACC_W-1:0] raw_sum;

	// exact product, both factors sign extended
	assign prod_full = ACC_W'(x_rd) * ACC_W'(y_rd);

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= prod_full;
		end
	end

	assign raw_sum = z_acc + prod_q;
	assign sat     = (z_acc[ACC_W-1] == prod_q[ACC_W-1]) &&
	                 (raw_sum[ACC_W-1] != z_acc[ACC_W-1]);
	assign sum     = sat ? (z_acc[ACC_W-1] ? ACC_MIN : ACC_MAX) : raw_sum;

endmodule

[rtl/mma_stores.sv]
module mma_stores
	import mma_pkg::*;
#(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF,
	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM,
	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  mma_ctl_t                 ctl,
	input  logic [AW-1:0]            addr_x,
	input  logic [AW-1:0]            addr_y,
	input  logic [AW-1:0]            addr_z,
	input  logic signed [FACT_W-1:0] factor_value,
	input  logic signed [ACC_W-1:0]  accum_value,
	input  logic signed [ACC_W-1:0]  mac_sum,
	output logic signed [FACT_W-1:0] x_rd,
	output logic signed [FACT_W-1:0] y_rd,
	output logic signed [ACC_W-1:0]  z_rd
);

	logic signed [FACT_W-1:0] x_mem [DEPTH];
	logic signed [FACT_W-1:0] y_mem [DEPTH];
	logic signed [ACC_W-1:0]  z_mem [DEPTH];

	logic signed [FACT_W-1:0] x_rd_q;
	logic signed [FACT_W-1:0] y_rd_q;
	logic signed [ACC_W-1:0]  z_rd_q;
	logic signed [ACC_W-1:0]  z_wdata;

	always_comb begin
		unique case (ctl.z_src)
			ZSRC_IN:   z_wdata = accum_value;
			ZSRC_ZERO: z_wdata = '0;
			ZSRC_MAC:  z_wdata = mac_sum;
			default:   z_wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.x_we) begin
			x_mem[addr_x] <= factor_value;
		end
		if (ctl.rd_en) begin
			x_rd_q <= x_mem[addr_x];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.y_we) begin
			y_mem[addr_y] <= factor_value;
		end
		if (ctl.rd_en) begin
			y_rd_q <= y_mem[addr_y];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.z_we) begin
			z_mem[addr_z] <= z_wdata;
		end
		if (ctl.rd_en) begin
			z_rd_q <= z_mem[addr_z];
		end
	end

	assign x_rd = x_rd_q;
	assign y_rd = y_rd_q;
	assign z_rd = z_rd_q;

endmodule

[rtl/mma_seq.sv]
module mma_seq
	import mma_pkg::*;
#(
	parameter int unsigned MAX_DIM = MAX_DIM_DEF,
	localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM,
	localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OP_W-1:0]         operation,
	input  logic [IDX_W-1:0]        row,
	input  logic [IDX_W-1:0]        col,
	input  logic                    cfg_write,
	input  logic [CFG_W-1:0]        cfg_index,
	input  logic [DIM_W-1:0]        cfg_data,
	input  logic                    mac_sat,
	input  logic signed [ACC_W-1:0] z_rd,
	output logic                    busy,
	output mma_ctl_t                ctl,
	output logic [AW-1:0]           addr_x,
	output logic [AW-1:0]           addr_y,
	output logic [AW-1:0]           addr_z,
	output logic                    result_valid,
	output logic                    result_kind,
	output logic signed [ACC_W-1:0] z_value,
	output logic                    overflow
);

	localparam int unsigned DIM_MAXV = (1 << DIM_W) - 1;
	localparam logic [DIM_W-1:0] DIM_CAP =
		DIM_W'((MAX_DIM > DIM_MAXV) ? DIM_MAXV : MAX_DIM);
	localparam logic [AW-1:0] MD_A     = AW'(MAX_DIM);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_CLR  = 3'd4;

	logic [2:0]       state_q;
	logic [DIM_W-1:0] rows_q, inner_q, cols_q;
	logic [DIM_W-1:0] n_dim, p_dim, m_dim;
	logic [DIM_W-1:0] i_q, j_q, k_q;
	logic [AW-1:0]    clr_q;
	logic             ovf_q;
	logic             valid_q, kind_q, ovf_out_q, rdok_q;

	logic             accept, in_store;
	logic             i_last, k_last, j_last, run_last;
	logic [AW-1:0]    in_addr;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_CAP) begin
			r = DIM_CAP;
		end
		return r;
	endfunction

	assign n_dim = clamp_dim(rows_q);
	assign p_dim = clamp_dim(inner_q);
	assign m_dim = clamp_dim(cols_q);

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && (state_q == S_IDLE);
	assign in_store = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign in_addr  = AW'(row) * MD_A + AW'(col);

	assign i_last   = (i_q == n_dim - DIM_W'(1));
	assign k_last   = (k_q == p_dim - DIM_W'(1));
	assign j_last   = (j_q == m_dim - DIM_W'(1));
	assign run_last = i_last && k_last && j_last;

	// address select: item address when idle, sweep when clearing, loop indices in a run
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				addr_x = in_addr;
				addr_y = in_addr;
				addr_z = in_addr;
			end
			S_CLR: begin
				addr_x = '0;
				addr_y = '0;
				addr_z = clr_q;
			end
			S_RD, S_MUL, S_ADD: begin
				addr_x = AW'(i_q) * MD_A + AW'(k_q);
				addr_y = AW'(k_q) * MD_A + AW'(j_q);
				addr_z = AW'(i_q) * MD_A + AW'(j_q);
			end
			default: begin
				addr_x = '0;
				addr_y = '0;
				addr_z = '0;
			end
		endcase
	end

	always_comb begin
		ctl.x_we   = accept && (operation == OP_WRITE_X) && in_store;
		ctl.y_we   = accept && (operation == OP_WRITE_Y) && in_store;
		ctl.z_we   = (accept && (operation == OP_WRITE_Z) && in_store) ||
		             (state_q == S_CLR) || (state_q == S_ADD);
		ctl.z_src  = (state_q == S_CLR) ? ZSRC_ZERO :
		             (state_q == S_ADD) ? ZSRC_MAC : ZSRC_IN;
		ctl.rd_en  = (state_q == S_RD) || (accept && (operation == OP_READ_Z));
		ctl.mul_en = (state_q == S_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_ROWS_X) begin
				rows_q <= cfg_data;
			end
			if (cfg_index == CFG_INNER_DIM) begin
				inner_q <= cfg_data;
			end
			if (cfg_index == CFG_COLS_Y) begin
				cols_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			clr_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && (operation == OP_RUN)) begin
						state_q <= S_RD;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						ovf_q   <= 1'b0;
					end else if (accept && (operation == OP_CLEAR_Z)) begin
						state_q <= S_CLR;
						clr_q   <= '0;
					end
				end
				S_RD: state_q <= S_MUL;
				S_MUL: state_q <= S_ADD;
				S_ADD: begin
					ovf_q <= ovf_q | mac_sat;
					if (run_last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD;
						if (!i_last) begin
							i_q <= i_q + DIM_W'(1);
						end else begin
							i_q <= '0;
							if (!k_last) begin
								k_q <= k_q + DIM_W'(1);
							end else begin
								k_q <= '0;
								j_q <= j_q + DIM_W'(1);
							end
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (accept && (operation == OP_READ_Z)) ||
			           ((state_q == S_ADD) && run_last);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (operation == OP_READ_Z)) begin
			kind_q    <= KIND_READ;
			ovf_out_q <= 1'b0;
			rdok_q    <= in_store;
		end else if ((state_q == S_ADD) && run_last) begin
			kind_q    <= KIND_RUN;
			ovf_out_q <= ovf_q | mac_sat;
			rdok_q    <= 1'b0;
		end
	end

	assign result_valid = valid_q;
	assign result_kind  = kind_q;
	assign overflow     = ovf_out_q;
	assign z_value      = rdok_q ? z_rd : '0;

endmodule
